[sv/art_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the ack retransmit tracker
package art_pkg;

  localparam int TableDepth = 8;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int DataW      = 32;
  localparam int HandleW    = 16;
  localparam int CfgW       = 16;
  localparam int TriesW     = 4;
  localparam int CfgIdxW    = 2;

  localparam logic [TriesW-1:0] TriesInit = TriesW'(1);

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PING        = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    KIND_STORED    = 4'd0,
    KIND_REPLACED  = 4'd1,
    KIND_FULL      = 4'd2,
    KIND_RELEASED  = 4'd3,
    KIND_NOTFOUND  = 4'd4,
    KIND_RESEND    = 4'd5,
    KIND_GIVEUP    = 4'd6,
    KIND_HEARTBEAT = 4'd7,
    KIND_NOTHING   = 4'd8
  } kind_e;

  // flags of the shared compare unit
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_flags_t;

endpackage

[sv/art_cmp_unit.sv]
`timescale 1ns / 1ps
// shared subtract and compare unit: wrapped difference, equal and unsigned less-than
module art_cmp_unit import art_pkg::*; (
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic [DataW-1:0] diff_o,
  output cmp_flags_t       flags_o
);

  logic [DataW:0] sub;

  // one extra bit keeps the borrow
  assign sub           = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o        = sub[DataW-1:0];
  assign flags_o.lt    = sub[DataW];
  assign flags_o.eq    = (a_i == b_i);

endmodule

[sv/ack_retransmit_tracker_top.sv]
`timescale 1ns / 1ps
// top level of the ack retransmit tracker: table, sequencer and result output
//
// keeps up to TableDepth messages that wait for an acknowledgement. a command beat
// is taken when start is high and busy is low; busy stays high until the last
// result of that command has been put out. every result is shown for exactly one
// cycle with res_valid_o high and cannot be held off, so the receiver must take
// it then; last_o marks the final result of a command. all work goes through one
// shared 32-bit subtract/compare unit under a small sequencer, one slot per cycle.
// enqueue and release walk all TableDepth slots looking for the id, then commit.
// a tick takes the valid entries in ascending id order by repeated minimum search:
// a pass over all TableDepth slots, then an elapsed-time step and a timeout check
// for each entry; then a closing pass, the heartbeat elapsed and ping checks and a
// step that puts out the final result. an unused opcode is dropped without any
// result. config writes are taken at any edge with cfg_we_i high and are meant for
// times when busy is low.
module ack_retransmit_tracker_top import art_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command beat
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [DataW-1:0]   msg_id_i,
  input  logic [HandleW-1:0] line_handle_i,
  input  logic [DataW-1:0]   now_ms_i,
  // result beat
  output logic               res_valid_o,
  output logic [3:0]         kind_o,
  output logic [DataW-1:0]   out_id_o,
  output logic [HandleW-1:0] out_handle_o,
  output logic [DataW-1:0]   out_time_o,
  output logic               last_o,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_ID,     // walk the slots looking for the id and a free slot
    ST_ENQ_WR,      // commit an enqueue
    ST_REL_WR,      // commit a release
    ST_TICK_SCAN,   // find the smallest id not yet handled in this tick
    ST_ELAPSED,     // elapsed time of the chosen entry
    ST_DUE,         // timeout check, resend or give up
    ST_HB_ELAPSED,  // elapsed time since the last heartbeat
    ST_HB_DUE,      // ping interval check
    ST_FLUSH        // put out the held result as the final one
  } state_e;

  localparam logic [SlotW-1:0] ScanLast = SlotW'(TableDepth - 1);

  // config registers
  logic [CfgW-1:0]   ack_timeout_q;
  logic [TriesW-1:0] retry_limit_q;
  logic [CfgW-1:0]   ping_q;

  // slot table
  logic [TableDepth-1:0] slot_valid_q;
  logic [DataW-1:0]      slot_id_q    [TableDepth];
  logic [TriesW-1:0]     slot_tries_q [TableDepth];
  logic [DataW-1:0]      slot_sent_q  [TableDepth];
  logic [HandleW-1:0]    slot_handle_q[TableDepth];
  logic [DataW-1:0]      last_hb_q;

  // sequencer state and command latch
  state_e                state_q;
  logic [1:0]            op_q;
  logic [DataW-1:0]      id_q;
  logic [HandleW-1:0]    handle_q;
  logic [DataW-1:0]      now_q;
  logic [SlotW-1:0]      scan_idx_q;
  logic                  hit_q;
  logic [SlotW-1:0]      hit_idx_q;
  logic                  free_q;
  logic [SlotW-1:0]      free_idx_q;
  logic [TableDepth-1:0] done_q;
  logic                  best_q;
  logic [SlotW-1:0]      best_idx_q;
  logic [DataW-1:0]      best_id_q;
  logic [DataW-1:0]      elapsed_q;

  // one result is held back until it is known whether another follows
  logic                  pend_vld_q;
  kind_e                 pend_kind_q;
  logic [DataW-1:0]      pend_id_q;
  logic [HandleW-1:0]    pend_handle_q;
  logic [DataW-1:0]      pend_time_q;

  // output registers
  logic                  res_valid_q;
  kind_e                 kind_q;
  logic [DataW-1:0]      out_id_q;
  logic [HandleW-1:0]    out_handle_q;
  logic [DataW-1:0]      out_time_q;
  logic                  last_q;

  // shared unit
  logic [DataW-1:0] cmp_a;
  logic [DataW-1:0] cmp_b;
  logic [DataW-1:0] cmp_diff;
  cmp_flags_t       cmp_flags;

  art_cmp_unit u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .diff_o  (cmp_diff),
    .flags_o (cmp_flags)
  );

  // operand selection per step
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      ST_SCAN_ID: begin
        cmp_a = slot_id_q[scan_idx_q];
        cmp_b = id_q;
      end
      ST_TICK_SCAN: begin
        cmp_a = slot_id_q[scan_idx_q];
        cmp_b = best_id_q;
      end
      ST_ELAPSED: begin
        cmp_a = now_q;
        cmp_b = slot_sent_q[best_idx_q];
      end
      ST_DUE: begin
        cmp_a = elapsed_q;
        cmp_b = DataW'(ack_timeout_q);
      end
      ST_HB_ELAPSED: begin
        cmp_a = now_q;
        cmp_b = last_hb_q;
      end
      ST_HB_DUE: begin
        cmp_a = elapsed_q;
        cmp_b = DataW'(ping_q);
      end
      default: ;
    endcase
  end

  logic              scan_last;
  logic              tick_take;
  logic              entry_due;
  logic              give_up;
  logic [TriesW-1:0] tries_sel;
  logic              enq_wr;
  logic [SlotW-1:0]  enq_idx;
  logic              resend_wr;

  assign scan_last = (scan_idx_q == ScanLast);
  // candidate not yet handled this tick, and smaller than the best so far
  assign tick_take = slot_valid_q[scan_idx_q] && !done_q[scan_idx_q] &&
                     (!best_q || cmp_flags.lt);
  assign entry_due = (state_q == ST_DUE) && !cmp_flags.lt;
  assign tries_sel = slot_tries_q[best_idx_q];
  assign give_up   = (tries_sel >= retry_limit_q);
  assign enq_wr    = (state_q == ST_ENQ_WR) && (hit_q || free_q);
  assign enq_idx   = hit_q ? hit_idx_q : free_idx_q;
  assign resend_wr = entry_due && !give_up;

  // result produced by a tick step
  logic               prod_vld;
  kind_e              prod_kind;
  logic [DataW-1:0]   prod_id;
  logic [HandleW-1:0] prod_handle;
  logic [DataW-1:0]   prod_time;
  logic               res_valid_d;

  always_comb begin
    prod_vld    = 1'b0;
    prod_kind   = KIND_NOTHING;
    prod_id     = '0;
    prod_handle = '0;
    prod_time   = '0;
    if (entry_due) begin
      prod_vld = 1'b1;
      prod_id  = best_id_q;
      if (give_up) begin
        prod_kind = KIND_GIVEUP;
      end else begin
        prod_kind   = KIND_RESEND;
        prod_handle = slot_handle_q[best_idx_q];
      end
    end else if ((state_q == ST_HB_DUE) && !cmp_flags.lt) begin
      prod_vld  = 1'b1;
      prod_kind = KIND_HEARTBEAT;
      prod_time = now_q;
    end
  end

  // a beat goes out when a held result is pushed or a command closes
  assign res_valid_d = (prod_vld && pend_vld_q) ||
                       (state_q inside {ST_ENQ_WR, ST_REL_WR, ST_FLUSH});

  // slot payload, written by enqueue and resend
  always_ff @(posedge clk_i) begin
    if (enq_wr) begin
      slot_id_q[enq_idx]     <= id_q;
      slot_tries_q[enq_idx]  <= TriesInit;
      slot_sent_q[enq_idx]   <= now_q;
      slot_handle_q[enq_idx] <= handle_q;
    end else if (resend_wr) begin
      slot_tries_q[best_idx_q] <= tries_sel + TriesInit;
      slot_sent_q[best_idx_q]  <= now_q;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= CfgW'(1000);
      retry_limit_q <= TriesW'(3);
      ping_q        <= CfgW'(5000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[TriesW-1:0];
        CFG_PING:        ping_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= '0;
      id_q          <= '0;
      handle_q      <= '0;
      now_q         <= '0;
      scan_idx_q    <= '0;
      hit_q         <= 1'b0;
      hit_idx_q     <= '0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      done_q        <= '0;
      best_q        <= 1'b0;
      best_idx_q    <= '0;
      best_id_q     <= '0;
      elapsed_q     <= '0;
      slot_valid_q  <= '0;
      last_hb_q     <= '0;
      pend_vld_q    <= 1'b0;
      pend_kind_q   <= KIND_NOTHING;
      pend_id_q     <= '0;
      pend_handle_q <= '0;
      pend_time_q   <= '0;
      res_valid_q   <= 1'b0;
      kind_q        <= KIND_NOTHING;
      out_id_q      <= '0;
      out_handle_q  <= '0;
      out_time_q    <= '0;
      last_q        <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;

      // a new tick result pushes the held one out as a non-final beat
      if (prod_vld) begin
        if (pend_vld_q) begin
          kind_q       <= pend_kind_q;
          out_id_q     <= pend_id_q;
          out_handle_q <= pend_handle_q;
          out_time_q   <= pend_time_q;
          last_q       <= 1'b0;
        end
        pend_vld_q    <= 1'b1;
        pend_kind_q   <= prod_kind;
        pend_id_q     <= prod_id;
        pend_handle_q <= prod_handle;
        pend_time_q   <= prod_time;
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            op_q       <= opcode_i;
            id_q       <= msg_id_i;
            handle_q   <= line_handle_i;
            now_q      <= now_ms_i;
            scan_idx_q <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            done_q     <= '0;
            best_q     <= 1'b0;
            case (opcode_i)
              OP_ENQUEUE, OP_RELEASE: state_q <= ST_SCAN_ID;
              OP_TICK:                state_q <= ST_TICK_SCAN;
              default:                state_q <= ST_IDLE;
            endcase
          end
        end

        ST_SCAN_ID: begin
          if (slot_valid_q[scan_idx_q] && cmp_flags.eq && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= scan_idx_q;
          end
          // lowest free slot wins
          if (!slot_valid_q[scan_idx_q] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= scan_idx_q;
          end
          if (scan_last) begin
            scan_idx_q <= '0;
            state_q    <= (op_q == OP_ENQUEUE) ? ST_ENQ_WR : ST_REL_WR;
          end else begin
            scan_idx_q <= scan_idx_q + SlotW'(1);
          end
        end

        ST_ENQ_WR: begin
          out_id_q     <= id_q;
          out_handle_q <= '0;
          out_time_q   <= '0;
          last_q       <= 1'b1;
          if (hit_q) begin
            kind_q <= KIND_REPLACED;
          end else if (free_q) begin
            kind_q                   <= KIND_STORED;
            slot_valid_q[free_idx_q] <= 1'b1;
          end else begin
            kind_q <= KIND_FULL;
          end
          state_q <= ST_IDLE;
        end

        ST_REL_WR: begin
          out_id_q     <= id_q;
          out_handle_q <= '0;
          out_time_q   <= '0;
          last_q       <= 1'b1;
          if (hit_q) begin
            kind_q                  <= KIND_RELEASED;
            slot_valid_q[hit_idx_q] <= 1'b0;
          end else begin
            kind_q <= KIND_NOTFOUND;
          end
          state_q <= ST_IDLE;
        end

        ST_TICK_SCAN: begin
          if (tick_take) begin
            best_q     <= 1'b1;
            best_idx_q <= scan_idx_q;
            best_id_q  <= slot_id_q[scan_idx_q];
          end
          if (scan_last) begin
            scan_idx_q <= '0;
            state_q    <= (best_q || tick_take) ? ST_ELAPSED : ST_HB_ELAPSED;
          end else begin
            scan_idx_q <= scan_idx_q + SlotW'(1);
          end
        end

        ST_ELAPSED: begin
          elapsed_q          <= cmp_diff;
          done_q[best_idx_q] <= 1'b1;
          state_q            <= ST_DUE;
        end

        ST_DUE: begin
          if (entry_due && give_up) begin
            slot_valid_q[best_idx_q] <= 1'b0;
          end
          best_q     <= 1'b0;
          scan_idx_q <= '0;
          state_q    <= ST_TICK_SCAN;
        end

        ST_HB_ELAPSED: begin
          elapsed_q <= cmp_diff;
          state_q   <= ST_HB_DUE;
        end

        ST_HB_DUE: begin
          if (!cmp_flags.lt) begin
            last_hb_q <= now_q;
          end
          state_q <= ST_FLUSH;
        end

        ST_FLUSH: begin
          last_q <= 1'b1;
          if (pend_vld_q) begin
            kind_q       <= pend_kind_q;
            out_id_q     <= pend_id_q;
            out_handle_q <= pend_handle_q;
            out_time_q   <= pend_time_q;
          end else begin
            kind_q       <= KIND_NOTHING;
            out_id_q     <= '0;
            out_handle_q <= '0;
            out_time_q   <= '0;
          end
          pend_vld_q <= 1'b0;
          state_q    <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_valid_o  = res_valid_q;
  assign kind_o       = kind_q;
  assign out_id_o     = out_id_q;
  assign out_handle_o = out_handle_q;
  assign out_time_o   = out_time_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  // a non-final beat always has more results behind it
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  // no held result may be left behind once the command is over
  a_no_stale_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_vld_q)
    else $error("held result lost at end of command");

  // heartbeat and nothing-due close a tick
  a_hb_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_HEARTBEAT || kind_o == KIND_NOTHING)) |-> last_o)
    else $error("heartbeat or nothing-due not marked last");

  // at most one slot gets occupied per cycle
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(slot_valid_q) <= $countones($past(slot_valid_q)) + 1))
    else $error("more than one slot filled in a cycle");
`endif

endmodule

[tb/ack_retransmit_tracker_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the ack retransmit tracker top level
module ack_retransmit_tracker_top_tb;
  import art_pkg::*;

  // opcode with no meaning, the block drops it without any result
  localparam logic [1:0] OpUnused = 2'd3;
  // worst command: full table scan per valid entry plus the closing steps
  localparam int SettleCycles = (TableDepth + 2) * (TableDepth + 1) + 10;
  localparam int IdPoolSize   = 12;
  localparam int NumPhases    = 6;
  localparam int PhaseItems   = 72;

  // one result beat as the block should put it out
  typedef struct {
    kind_e               kind;
    logic [DataW-1:0]    id;
    logic [HandleW-1:0]  handle;
    logic [DataW-1:0]    stamp;
    logic                last;
  } result_t;

  // table predictor plus the queue of results still owed by the block
  class tracker_scoreboard;
    bit                  live [TableDepth];
    logic [DataW-1:0]    entry_id [TableDepth];
    logic [TriesW-1:0]   entry_tries [TableDepth];
    logic [DataW-1:0]    entry_stamp [TableDepth];
    logic [HandleW-1:0]  entry_handle [TableDepth];
    logic [DataW-1:0]    last_ping_ms;
    logic [CfgW-1:0]     timeout_ms;
    logic [TriesW-1:0]   retry_cap;
    logic [CfgW-1:0]     ping_ms;

    result_t owed_results[$];
    result_t batch[$];
    int      errors;
    int      commands;
    int      checked;
    int      kind_seen [9];

    function new();
      foreach (live[i]) live[i] = 1'b0;
      last_ping_ms = '0;
      timeout_ms   = 16'd1000;
      retry_cap    = 4'd3;
      ping_ms      = 16'd5000;
      errors       = 0;
      commands     = 0;
      checked      = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
      case (idx)
        CFG_ACK_TIMEOUT: timeout_ms = value;
        CFG_RETRY_LIMIT: retry_cap  = value[TriesW-1:0];
        CFG_PING:        ping_ms    = value;
        default: ;
      endcase
    endfunction

    function int find_entry(input logic [DataW-1:0] id);
      for (int i = 0; i < TableDepth; i++)
        if (live[i] && entry_id[i] == id) return i;
      return -1;
    endfunction

    function void emit(input kind_e kind, input logic [DataW-1:0] id,
                       input logic [HandleW-1:0] handle, input logic [DataW-1:0] stamp);
      result_t r;
      r.kind   = kind;
      r.id     = id;
      r.handle = handle;
      r.stamp  = stamp;
      r.last   = 1'b0;
      batch.push_back(r);
    endfunction

    // works out every result of one accepted command
    function void note_command(input logic [1:0] op, input logic [DataW-1:0] id,
                               input logic [HandleW-1:0] handle,
                               input logic [DataW-1:0] now);
      int               slot;
      int               count;
      int               j;
      int               s;
      int               order [TableDepth];
      logic [DataW-1:0] elapsed;
      kind_e            kind;

      batch.delete();
      commands++;
      case (op)
        OP_ENQUEUE: begin
          slot = find_entry(id);
          kind = KIND_REPLACED;
          if (slot < 0) begin
            kind = KIND_STORED;
            for (int i = TableDepth - 1; i >= 0; i--)
              if (!live[i]) slot = i;
          end
          if (slot < 0) begin
            kind = KIND_FULL;
          end else begin
            live[slot]         = 1'b1;
            entry_id[slot]     = id;
            entry_tries[slot]  = TriesInit;
            entry_stamp[slot]  = now;
            entry_handle[slot] = handle;
          end
          emit(kind, id, '0, '0);
        end
        OP_RELEASE: begin
          slot = find_entry(id);
          if (slot >= 0) live[slot] = 1'b0;
          emit(slot >= 0 ? KIND_RELEASED : KIND_NOTFOUND, id, '0, '0);
        end
        OP_TICK: begin
          // live entries sorted by ascending id
          count = 0;
          for (int i = 0; i < TableDepth; i++) begin
            if (live[i]) begin
              j = count;
              while (j > 0 && entry_id[order[j-1]] > entry_id[i]) begin
                order[j] = order[j-1];
                j--;
              end
              order[j] = i;
              count++;
            end
          end
          for (int k = 0; k < count; k++) begin
            s = order[k];
            elapsed = now - entry_stamp[s];
            if (elapsed >= DataW'(timeout_ms)) begin
              if (entry_tries[s] >= retry_cap) begin
                live[s] = 1'b0;
                emit(KIND_GIVEUP, entry_id[s], '0, '0);
              end else begin
                entry_tries[s] = entry_tries[s] + 1'b1;
                entry_stamp[s] = now;
                emit(KIND_RESEND, entry_id[s], entry_handle[s], '0);
              end
            end
          end
          elapsed = now - last_ping_ms;
          if (elapsed >= DataW'(ping_ms)) begin
            last_ping_ms = now;
            emit(KIND_HEARTBEAT, '0, '0, now);
          end
          if (batch.size() == 0) emit(KIND_NOTHING, '0, '0, '0);
        end
        default: ;
      endcase
      if (batch.size() != 0) begin
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) owed_results.push_back(batch[i]);
      end
    endfunction

    function void check_result(input logic [3:0] kind, input logic [DataW-1:0] id,
                               input logic [HandleW-1:0] handle,
                               input logic [DataW-1:0] stamp, input logic last);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d id %h", $time, kind, id);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      kind_seen[want.kind]++;
      if (kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d got %0d", $time, want.kind, kind);
        errors++;
      end
      if (id !== want.id) begin
        $display("%0t: id mismatch, expected %h got %h", $time, want.id, id);
        errors++;
      end
      if (handle !== want.handle) begin
        $display("%0t: handle mismatch, expected %h got %h", $time, want.handle, handle);
        errors++;
      end
      if (stamp !== want.stamp) begin
        $display("%0t: time mismatch, expected %h got %h", $time, want.stamp, stamp);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch, expected %b got %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         opcode_i;
  logic [DataW-1:0]   msg_id_i;
  logic [HandleW-1:0] line_handle_i;
  logic [DataW-1:0]   now_ms_i;
  logic               res_valid_o;
  logic [3:0]         kind_o;
  logic [DataW-1:0]   out_id_o;
  logic [HandleW-1:0] out_handle_o;
  logic [DataW-1:0]   out_time_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  tracker_scoreboard  sb;
  logic [DataW-1:0]   id_pool [IdPoolSize];
  // running millisecond clock of the stimulus, wraps freely
  logic [DataW-1:0]   clock_ms;

  ack_retransmit_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .msg_id_i      (msg_id_i),
    .line_handle_i (line_handle_i),
    .now_ms_i      (now_ms_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .out_id_o      (out_id_o),
    .out_handle_o  (out_handle_o),
    .out_time_o    (out_time_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // results cannot be held off, so every strobed cycle is checked
  always @(posedge clk_i) begin
    if (res_valid_o === 1'b1)
      sb.check_result(kind_o, out_id_o, out_handle_o, out_time_o, last_o);
  end

  // called right after a falling edge, returns right after one
  task automatic send_command(input logic [1:0] op, input logic [DataW-1:0] id,
                              input logic [HandleW-1:0] handle,
                              input logic [DataW-1:0] now);
    opcode_i      = op;
    msg_id_i      = id;
    line_handle_i = handle;
    now_ms_i      = now;
    start         = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // the beat is taken at this edge
    sb.note_command(op, id, handle, now);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
  endtask

  // hold off the sender until every owed result has come out
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // idle point for register writes: no command left in flight
  task automatic settle();
    drain();
    while (busy) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // mostly pool ids so replace, release, full table and retries all happen
  task automatic run_phase(input int items, input int unsigned idle_pct,
                           input int unsigned span);
    int               made;
    int unsigned      pick;
    logic [1:0]       op;
    logic [DataW-1:0] id;
    logic [DataW-1:0] now;
    made = 0;
    while (made < items) begin
      pick = $urandom_range(99);
      id   = ($urandom_range(9) == 0) ? DataW'($urandom)
                                      : id_pool[$urandom_range(IdPoolSize - 1)];
      if (pick < 42) begin
        op = OP_ENQUEUE;
        clock_ms = clock_ms + $urandom_range(span / 4);
      end else if (pick < 62) begin
        op = OP_RELEASE;
      end else if (pick < 96) begin
        op = OP_TICK;
        clock_ms = clock_ms + $urandom_range(span);
      end else begin
        op = OpUnused;
      end
      // a few stray times that jump anywhere
      now = ($urandom_range(19) == 0) ? DataW'($urandom) : clock_ms;
      idle_gap(idle_pct);
      send_command(op, id, HandleW'($urandom), now);
      if (op != OpUnused) made++;
      if ($urandom_range(99) < 2) drain();
    end
  endtask

  initial begin : stimulus
    int unsigned t_ms;
    int unsigned cap;
    int unsigned ping;
    int unsigned idle;
    int unsigned span;

    sb            = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = '0;
    msg_id_i      = '0;
    line_handle_i = '0;
    now_ms_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    id_pool[0]    = '0;
    id_pool[1]    = '1;
    for (int i = 2; i < IdPoolSize; i++) id_pool[i] = $urandom;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset settings: timeout 1000, limit 3, ping 5000
    send_command(OP_TICK, '1, '0, 32'd0);             // empty table, nothing due
    send_command(OP_TICK, '0, '0, 32'hFFFF_FFFF);     // heartbeat only
    send_command(OP_ENQUEUE, 32'h0, 16'h0000, 32'hFFFF_FC00);
    send_command(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_command(OP_ENQUEUE, 32'hFFFF_FFFF, 16'h5A5A, 32'd10);  // same id overwrites
    send_command(OP_RELEASE, 32'h1234_5678, '0, '0);            // absent id
    send_command(OP_ENQUEUE, 32'h8000_0000, 16'h8001, 32'd100);
    send_command(OP_ENQUEUE, 32'h5555_5555, 16'h5555, 32'd100);
    send_command(OP_ENQUEUE, 32'hAAAA_AAAA, 16'hAAAA, 32'd100);
    send_command(OP_ENQUEUE, 32'd7, 16'h0007, 32'd100);
    send_command(OP_ENQUEUE, 32'd3, 16'h0003, 32'd100);
    send_command(OP_ENQUEUE, 32'h0F0F_0F0F, 16'hF0F0, 32'd100);
    send_command(OP_ENQUEUE, 32'd42, 16'h002A, 32'd100);        // table full
    send_command(OP_RELEASE, 32'h5555_5555, '0, '0);
    send_command(OP_TICK, '0, '0, 32'd24);     // wrapped elapsed time reaches timeout
    send_command(OP_TICK, '0, '0, 32'd3000);   // all due, resends in id order
    send_command(OP_TICK, '0, '0, 32'd4100);   // all entries but id FFFF_FFFF give up
    send_command(OP_TICK, '0, '0, 32'd5200);   // rest give up, then heartbeat
    send_command(OpUnused, '1, '1, '1);        // dropped without result
    send_command(OP_RELEASE, 32'hFFFF_FFFF, '0, '0);

    // random phases, each at its own register setting and idle pattern
    clock_ms = 32'hFFFE_0000;
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin t_ms = 200;   cap = 2;  ping = 700;   idle = 0;  end
        1: begin t_ms = 65535; cap = 15; ping = 65535; idle = 59; end
        2: begin
          // lowered limit leaves older entries above it
          t_ms = $urandom_range(1, 300);
          cap  = $urandom_range(1, 5);
          ping = $urandom_range(1, 2000);
          idle = 0;
        end
        3: begin t_ms = 0; cap = 0; ping = 0; idle = 23; end   // all due, all given up
        4: begin t_ms = 1; cap = 1; ping = 1; idle = 0;  end
        default: begin
          t_ms = $urandom_range(1, 65535);
          cap  = $urandom_range(1, 15);
          ping = $urandom_range(1, 65535);
          idle = 59;
        end
      endcase
      span = 2 * t_ms + 4;
      write_register(CFG_ACK_TIMEOUT, CfgW'(t_ms));
      write_register(CFG_RETRY_LIMIT, CfgW'(cap));
      write_register(CFG_PING, CfgW'(ping));
      id_pool[$urandom_range(2, IdPoolSize - 1)] = $urandom;
      run_phase(PhaseItems, idle, span);
    end

    settle();
    $display("covered %0d commands over %0d register settings, %0d results checked",
             sb.commands, NumPhases + 1, sb.checked);
    $display("resend %0d, give up %0d, heartbeat %0d, table full %0d, nothing due %0d",
             sb.kind_seen[KIND_RESEND], sb.kind_seen[KIND_GIVEUP],
             sb.kind_seen[KIND_HEARTBEAT], sb.kind_seen[KIND_FULL],
             sb.kind_seen[KIND_NOTHING]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
